>>> hw/rtl/pcst_pkg.sv
// Shared types and constants for the pin change subscription table.
// Holds the transaction structs, the slot record, codes and controller states.
// No dependencies.
package pcst_pkg;

   // Table geometry.
   localparam int SLOTS = 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Period used when a subscription asks for zero.
   localparam logic [15:0] DEFAULT_PERIOD = 16'd100;

   typedef enum logic [1:0] {
      MODE_SUBSCRIBE   = 2'd0,
      MODE_UNSUBSCRIBE = 2'd1,
      MODE_RESET       = 2'd2,
      MODE_SAMPLE      = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REPLY_ACK   = 2'd0,
      REPLY_NAK   = 2'd1,
      REPLY_EVENT = 2'd2
   } reply_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_UNKNOWN_PIN = 2'd1,
      ERR_NO_SLOT     = 2'd2
   } error_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  pin;
      logic [7:0]  report_kind;
      logic [15:0] period_ms;
      logic [15:0] deadband;
      logic [15:0] sample;
      logic [31:0] time_ms;
   } req_type;

   typedef struct packed {
      reply_type   reply_kind;
      error_type   error_kind;
      logic [7:0]  event_pin;
      logic [15:0] event_sample;
   } rsp_type;

   // One stored subscription.
   typedef struct packed {
      logic [7:0]  pin;
      logic [7:0]  kind;
      logic [15:0] period;
      logic [15:0] deadband;
      logic [15:0] last_sample;
      logic [31:0] last_time;
   } slot_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic exec;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic found;
      logic miss;
   } status_type;

endpackage

>>> hw/rtl/pin_change_subscription_table_unit.sv
// A result strobe follows the slot scan, the execution state and the result register.
// The slot scan reads one record a cycle from the slot RAM and stops at the first
// active slot that holds the pin, or after the last used slot when none does.
// One transaction is handled at a time; the next is accepted in the strobe cycle.
// Reset is synchronous: the table is emptied and the poll kind register cleared.
// The receiver cannot stall; a sample that causes no report gives no strobe.
module pin_change_subscription_table_unit
   import pcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   pcst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Table storage and update logic.
   pcst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> hw/rtl/pcst_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Used for the slot records. No dependencies.
module pcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pcst_datapath.sv
// Datapath of the subscription table: request register, slot RAM, active bits,
// scan pointer, update logic and result register. Depends on pcst_pkg, pcst_ram.
module pcst_datapath
   import pcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_strobe,
   output rsp_type    rsp_data
);

   localparam int SLOT_W = $bits(slot_type);

   req_type            req_ff;
   logic [7:0]         poll_kind_ff;
   logic [SLOTS-1:0]   active_ff, active_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   scan_idx_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic               hit_ff;
   logic [IDX_W-1:0]   hit_idx_ff;
   slot_type           hit_rec_ff;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic [SLOT_W-1:0]  rd_word;
   slot_type           rd_slot;
   logic               issue;
   logic               match;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_type           wr_data;
   slot_type           new_rec;
   slot_type           upd_rec;
   logic [31:0]        elapsed;
   logic               due;
   logic [15:0]        delta;
   logic               moved;
   logic               full;

   // Slot record storage.
   pcst_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_idx_ff[IDX_W-1:0]),
      .rd_data (rd_word)
   );

   assign rd_slot = rd_word;

   // Scan compare: the record read in the previous cycle is checked here.
   assign issue  = scan_idx_ff < used_ff;
   assign match  = pend_ff && active_ff[pend_idx_ff] && (rd_slot.pin == req_ff.pin);
   assign status = '{found: match, miss: !match && !issue};

   // Arithmetic on the matched record.
   assign elapsed = req_ff.time_ms - hit_rec_ff.last_time;
   assign due     = elapsed >= {16'd0, hit_rec_ff.period};
   assign delta   = (req_ff.sample > hit_rec_ff.last_sample) ?
                    (req_ff.sample - hit_rec_ff.last_sample) :
                    (hit_rec_ff.last_sample - req_ff.sample);
   assign moved   = delta >= hit_rec_ff.deadband;
   assign full    = used_ff == CNT_W'(SLOTS);

   // Fresh record for a subscription.
   always_comb begin
      new_rec.pin         = req_ff.pin;
      new_rec.kind        = req_ff.report_kind;
      new_rec.period      = (req_ff.period_ms == 16'd0) ? DEFAULT_PERIOD : req_ff.period_ms;
      new_rec.deadband    = req_ff.deadband;
      new_rec.last_sample = 16'd0;
      new_rec.last_time   = req_ff.time_ms;
   end

   // Record after a sample that fell due.
   always_comb begin
      upd_rec           = hit_rec_ff;
      upd_rec.last_time = req_ff.time_ms;
      if (moved) begin
         upd_rec.last_sample = req_ff.sample;
      end
   end

   // Execution of the transaction once the scan is over.
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = new_rec;
      active_in     = active_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{reply_kind: REPLY_ACK, error_kind: ERR_NONE,
                        event_pin: 8'd0, event_sample: 16'd0};
      if (cmd.exec) begin
         case (req_ff.mode)
            MODE_SUBSCRIBE: begin
               rsp_strobe_in = 1'b1;
               if (hit_ff) begin
                  wr_en = 1'b1;
               end else if (full) begin
                  rsp_in.reply_kind = REPLY_NAK;
                  rsp_in.error_kind = ERR_NO_SLOT;
               end else begin
                  wr_en                          = 1'b1;
                  wr_addr                        = used_ff[IDX_W-1:0];
                  active_in[used_ff[IDX_W-1:0]]  = 1'b1;
                  used_in                        = used_ff + CNT_W'(1);
               end
            end
            MODE_UNSUBSCRIBE: begin
               rsp_strobe_in = 1'b1;
               if (hit_ff) begin
                  active_in[hit_idx_ff] = 1'b0;
               end else begin
                  rsp_in.reply_kind = REPLY_NAK;
                  rsp_in.error_kind = ERR_UNKNOWN_PIN;
               end
            end
            MODE_RESET: begin
               rsp_strobe_in = 1'b1;
               active_in     = '0;
               used_in       = '0;
            end
            MODE_SAMPLE: begin
               if (hit_ff && (hit_rec_ff.kind == poll_kind_ff) && due) begin
                  wr_en   = 1'b1;
                  wr_data = upd_rec;
                  if (moved) begin
                     rsp_strobe_in       = 1'b1;
                     rsp_in.reply_kind   = REPLY_EVENT;
                     rsp_in.event_pin    = req_ff.pin;
                     rsp_in.event_sample = req_ff.sample;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_kind_ff  <= 8'd0;
         active_ff     <= '0;
         used_ff       <= '0;
         scan_idx_ff   <= '0;
         pend_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            poll_kind_ff <= csr_wdata;
         end
         active_ff     <= active_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (cmd.load) begin
            scan_idx_ff <= '0;
            pend_ff     <= 1'b0;
            hit_ff      <= 1'b0;
         end else if (cmd.step) begin
            if (issue) begin
               scan_idx_ff <= scan_idx_ff + CNT_W'(1);
            end
            pend_ff <= issue;
            if (match) begin
               hit_ff <= 1'b1;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.step) begin
         pend_idx_ff <= scan_idx_ff[IDX_W-1:0];
         if (match) begin
            hit_idx_ff <= pend_idx_ff;
            hit_rec_ff <= rd_slot;
         end
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> hw/rtl/pcst_ctrl.sv
// Controller of the subscription table: sequences load, slot scan and execution.
// Depends on pcst_pkg.
module pcst_ctrl
   import pcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '{load: 1'b0, step: 1'b0, exec: 1'b0};
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (status.found || status.miss) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/pcst_checker.sv
// Port-level checks for the subscription table, bound to the top level.
// Depends on pcst_pkg and pin_change_subscription_table_unit.
module pcst_checker
   import pcst_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input rsp_type    rsp_data
);

   // An accepted transaction keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after an accepted transaction");

   // Result strobes never come back to back, as every transaction passes the scan and execution states.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // Acks and naks carry no event pin or reading.
   a_reply_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.reply_kind != REPLY_EVENT) |->
         (rsp_data.event_pin == 8'd0) && (rsp_data.event_sample == 16'd0))
      else $error("ack or nak carries event payload");

   // A nak always names an error, and nothing else does.
   a_nak_error: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         ((rsp_data.reply_kind == REPLY_NAK) == (rsp_data.error_kind != ERR_NONE)))
      else $error("error kind disagrees with reply kind");

endmodule

bind pin_change_subscription_table_unit pcst_checker u_checker (.*);

>>> sim/pcst_reply_watch.sv
// Watches the transactions of the pin change subscription table and checks replies.
// Keeps its own copy of the slot table and the poll kind register, built from pcst_pkg.
// Depends on pcst_pkg only.
module pcst_reply_watch
   import pcst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_strobe,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output int         fail_count,
   output int         replies_pending
);

   // Predicted table contents.
   slot_type   slot_rec [SLOTS];
   bit         slot_live [SLOTS];
   int         used_slots;
   logic [7:0] poll_kind;

   // Replies still owed by the block, oldest first.
   rsp_type    expected_replies [$];
   int         fails = 0;
   int         pending_q = 0;

   assign fail_count      = fails;
   assign replies_pending = pending_q;

   // Lowest slot in use that holds a live subscription for the pin, or -1.
   function automatic int find_live_slot(input logic [7:0] pin);
      for (int i = 0; i < used_slots && i < SLOTS; i++) begin
         if (slot_live[i] && slot_rec[i].pin == pin)
            return i;
      end
      return -1;
   endfunction

   // A subscription refreshes everything but the pin.
   task automatic refill_slot(input int s, input req_type r);
      slot_rec[s].kind        = r.report_kind;
      slot_rec[s].period      = (r.period_ms == 16'd0) ? DEFAULT_PERIOD : r.period_ms;
      slot_rec[s].deadband    = r.deadband;
      slot_rec[s].last_sample = 16'd0;
      slot_rec[s].last_time   = r.time_ms;
   endtask

   // Applies one accepted transaction to the table and queues the reply it owes.
   task automatic predict_reply(input req_type r);
      int          s;
      bit          emit;
      rsp_type     reply;
      logic [31:0] elapsed;
      logic [15:0] last;
      logic [15:0] delta;
      reply = '0;
      emit  = 1'b0;
      s     = find_live_slot(r.pin);
      case (r.mode)
         MODE_SUBSCRIBE: begin
            emit = 1'b1;
            if (s >= 0) begin
               refill_slot(s, r);
            end else if (used_slots >= SLOTS) begin
               reply.reply_kind = REPLY_NAK;
               reply.error_kind = ERR_NO_SLOT;
            end else begin
               slot_rec[used_slots].pin = r.pin;
               refill_slot(used_slots, r);
               slot_live[used_slots] = 1'b1;
               used_slots++;
            end
         end
         MODE_UNSUBSCRIBE: begin
            emit = 1'b1;
            if (s < 0) begin
               reply.reply_kind = REPLY_NAK;
               reply.error_kind = ERR_UNKNOWN_PIN;
            end else begin
               slot_live[s] = 1'b0;
            end
         end
         MODE_RESET: begin
            emit = 1'b1;
            for (int i = 0; i < SLOTS; i++)
               slot_live[i] = 1'b0;
            used_slots = 0;
         end
         MODE_SAMPLE: begin
            // Only live poll entries whose period has run out are looked at.
            if (s >= 0 && slot_rec[s].kind == poll_kind) begin
               elapsed = r.time_ms - slot_rec[s].last_time;
               if (elapsed >= {16'd0, slot_rec[s].period}) begin
                  last  = slot_rec[s].last_sample;
                  delta = (r.sample > last) ? r.sample - last : last - r.sample;
                  if (delta >= slot_rec[s].deadband) begin
                     emit               = 1'b1;
                     reply.reply_kind   = REPLY_EVENT;
                     reply.event_pin    = r.pin;
                     reply.event_sample = r.sample;
                     slot_rec[s].last_sample = r.sample;
                  end
                  slot_rec[s].last_time = r.time_ms;
               end
            end
         end
         default: ;
      endcase
      if (emit)
         expected_replies.push_back(reply);
   endtask

   // Compares one reply with the oldest one owed.
   task automatic compare_reply(input rsp_type got);
      rsp_type want;
      if (expected_replies.size() == 0) begin
         $error("reply with none owed: reply_kind %0d error_kind %0d pin %0d sample %0d",
                got.reply_kind, got.error_kind, got.event_pin, got.event_sample);
         fails++;
      end else begin
         want = expected_replies.pop_front();
         if (got.reply_kind !== want.reply_kind) begin
            $error("reply_kind: expected %0d, actual %0d", want.reply_kind, got.reply_kind);
            fails++;
         end
         if (got.error_kind !== want.error_kind) begin
            $error("error_kind: expected %0d, actual %0d", want.error_kind, got.error_kind);
            fails++;
         end
         if (got.event_pin !== want.event_pin) begin
            $error("event_pin: expected %0d, actual %0d", want.event_pin, got.event_pin);
            fails++;
         end
         if (got.event_sample !== want.event_sample) begin
            $error("event_sample: expected %0d, actual %0d",
                   want.event_sample, got.event_sample);
            fails++;
         end
      end
   endtask

   // Everything is sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_live[i] = 1'b0;
         used_slots = 0;
         poll_kind  = 8'd0;
         expected_replies.delete();
      end else begin
         if (rsp_strobe)
            compare_reply(rsp_data);
         if (csr_we)
            poll_kind = csr_wdata;
         if (start && !busy)
            predict_reply(req_data);
      end
      pending_q <= expected_replies.size();
   end

endmodule

>>> sim/pin_change_subscription_table_unit_test.sv
// Top level of the pin change subscription table test: clock, reset and stimulus.
// Instantiates the block and the reply watcher; depends on pcst_pkg and both modules.
module pin_change_subscription_table_unit_test;
   import pcst_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS  = 120;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       start     = 1'b0;
   req_type    req_data  = '0;
   logic       csr_we    = 1'b0;
   logic [7:0] csr_wdata = 8'd0;
   logic       busy;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   int         fail_count;
   int         replies_pending;
   int         cycle_count = 0;

   // Time base and poll kind used to shape the random transactions.
   logic [31:0] now_ms   = 32'd0;
   logic [7:0]  poll_now = 8'd0;

   pin_change_subscription_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   pcst_reply_watch reply_watch (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   always #5 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type make_req(input mode_type m, input logic [7:0] pin,
                                         input logic [7:0] kind, input logic [15:0] period,
                                         input logic [15:0] deadband,
                                         input logic [15:0] sample, input logic [31:0] t);
      req_type r;
      r.mode        = m;
      r.pin         = pin;
      r.report_kind = kind;
      r.period_ms   = period;
      r.deadband    = deadband;
      r.sample      = sample;
      r.time_ms     = t;
      return r;
   endfunction

   // Mostly short gaps, a few long ones, and whole stretches without any.
   function automatic int pick_gap(input int n);
      int r;
      r = $urandom_range(0, 99);
      if ((n / 50) % 4 == 3) return 0;
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   // Offers one transaction and holds it until the block takes it.
   task automatic send_request(input req_type r, input int gap);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every owed reply and for a sample that reports nothing to finish.
   task automatic wait_quiet(input int tail);
      start <= 1'b0;
      do @(posedge clock); while (replies_pending != 0 || busy);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_poll_kind(input logic [7:0] v);
      wait_quiet(16);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      poll_now  = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A random transaction over a small pin pool, with time moving forward.
   function automatic req_type random_request();
      req_type  r;
      int       pick;
      mode_type m;
      pick = $urandom_range(0, 99);
      if (pick < 28)      m = MODE_SUBSCRIBE;
      else if (pick < 38) m = MODE_UNSUBSCRIBE;
      else if (pick < 42) m = MODE_RESET;
      else                m = MODE_SAMPLE;
      r.mode = m;
      r.pin  = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 9))
                                            : 8'($urandom_range(0, 255));
      r.report_kind = ($urandom_range(0, 99) < 75) ? poll_now : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.period_ms = 16'($urandom_range(1, 60));
      else if (pick < 65) r.period_ms = 16'd0;
      else if (pick < 90) r.period_ms = 16'($urandom_range(61, 300));
      else                r.period_ms = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 40)      r.deadband = 16'($urandom_range(1, 50));
      else if (pick < 60) r.deadband = 16'd0;
      else if (pick < 85) r.deadband = 16'($urandom_range(51, 2000));
      else                r.deadband = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 10)      r.sample = 16'd0;
      else if (pick < 20) r.sample = 16'hFFFF;
      else                r.sample = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 70)      now_ms = now_ms + $urandom_range(0, 150);
      else if (pick < 92) now_ms = now_ms + $urandom_range(0, 20);
      else                now_ms = now_ms + $urandom();
      // Now and then a time out of order, far ahead or behind.
      r.time_ms = ($urandom_range(0, 99) < 5) ? $urandom() : now_ms;
      return r;
   endfunction

   initial begin
      logic [7:0] phase_kinds [6];
      int         n;
      phase_kinds = '{8'hFF, 8'h5A, 8'h00, 8'h01, 8'h80, 8'h00};
      phase_kinds[2] = 8'($urandom_range(0, 255));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the poll kind at zero.
      write_poll_kind(8'h00);
      send_request(make_req(MODE_UNSUBSCRIBE, 8'd5, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0), 0);
      send_request(make_req(MODE_SAMPLE, 8'd5, 8'd0, 16'd0, 16'd0, 16'd7, 32'd500), 1);
      send_request(make_req(MODE_SUBSCRIBE, 8'd0, 8'd0, 16'd0, 16'd10, 16'd0, 32'd1000), 0);
      // Too early, then a change below the deadband, then a reported change.
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd900, 32'd1050), 0);
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd5, 32'd1100), 2);
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 32'd1200), 0);
      // Update in place, then a sample across the wrap of the time base.
      send_request(make_req(MODE_SUBSCRIBE, 8'd0, 8'd0, 16'd1, 16'd0, 16'd0,
                            32'hFFFF_FFFF), 0);
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0), 0);
      // An entry of another kind never reports.
      send_request(make_req(MODE_SUBSCRIBE, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'd0,
                            32'd0), 0);
      send_request(make_req(MODE_SAMPLE, 8'd255, 8'd0, 16'd0, 16'd0, 16'hFFFF,
                            32'h8000_0000), 3);
      for (int p = 1; p <= 6; p++)
         send_request(make_req(MODE_SUBSCRIBE, 8'(p), 8'(p), 16'(p), 16'd0, 16'd0,
                               32'd2000), 0);
      // Table full; an unsubscribed slot is not given back.
      send_request(make_req(MODE_SUBSCRIBE, 8'd7, 8'd0, 16'd0, 16'd0, 16'd0, 32'd2100), 0);
      send_request(make_req(MODE_UNSUBSCRIBE, 8'd3, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0), 0);
      send_request(make_req(MODE_SUBSCRIBE, 8'd7, 8'd0, 16'd0, 16'd0, 16'd0, 32'd2200), 1);
      send_request(make_req(MODE_UNSUBSCRIBE, 8'd3, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0), 0);
      send_request(make_req(MODE_SUBSCRIBE, 8'd255, 8'd0, 16'd3, 16'd3, 16'd0, 32'd2300), 0);
      send_request(make_req(MODE_RESET, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0, 32'd0), 0);
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 32'd9000), 0);
      // Largest period and deadband, met exactly.
      send_request(make_req(MODE_SUBSCRIBE, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'd0, 32'd5), 0);
      send_request(make_req(MODE_SAMPLE, 8'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 32'd65540), 0);

      // Random phases, each under its own poll kind; some start close to the wrap.
      n = 0;
      for (int ph = 0; ph < 6; ph++) begin
         write_poll_kind(phase_kinds[ph]);
         now_ms = (ph % 3 == 1) ? 32'hFFFF_F000 + $urandom_range(0, 2000) : $urandom();
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_request(random_request(), pick_gap(n));
            n++;
         end
      end

      wait_quiet(20);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pcst_pkg.sv
hw/rtl/pcst_ram.sv
hw/rtl/pcst_datapath.sv
hw/rtl/pcst_ctrl.sv
hw/rtl/pin_change_subscription_table_unit.sv
hw/rtl/pcst_checker.sv
sim/pcst_reply_watch.sv
sim/pin_change_subscription_table_unit_test.sv
